FILE: design/kon_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kon_pkg
// shared constants, codes and types of the k-out-of-n reliability block
// ----------------------------------------------------------------------------
package kon_pkg;

    // largest number of components that the coefficient table supports
    localparam int MAX_COMPONENTS = 32;

    localparam int TABLE_DEPTH = MAX_COMPONENTS + 1;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    // counts must hold the 6-bit register values and the clamped n
    localparam int CNT_W       = (ADDR_W > 6) ? ADDR_W : 6;

    localparam int Q_W     = 32;
    localparam int COEF_W  = 30;
    localparam int PROD_W  = 2 * Q_W;
    localparam int TERM_W  = COEF_W + Q_W - 1;
    localparam int ACC_W   = 63;
    localparam int FIELD_W = 6;

    localparam logic [Q_W-1:0]    Q_ONE   = 32'h8000_0000;
    localparam logic [PROD_W-1:0] Q_HALF  = 64'h0000_0000_4000_0000;
    localparam logic [ACC_W-1:0]  ACC_CAP = 63'h4000_0000_0000_0000;

    // stream layout
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 32;

    // request kinds carried in s_tuser
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EVAL = 1'b1;

    // configuration register indexes
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 6;
    localparam logic [CFG_ADDR_W-1:0] REG_NUM_COMPONENTS  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_THRESHOLD_COUNT = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_METHOD          = 2'd2;

    // method codes
    localparam logic METHOD_SUCCESS = 1'b0;
    localparam logic METHOD_FAILURE = 1'b1;

    typedef struct packed {
        logic [FIELD_W-1:0] num_components;
        logic [FIELD_W-1:0] threshold_count;
        logic               method;
    } kon_cfg_t;

    typedef struct packed {
        logic           valid;
        logic [Q_W-1:0] value;
        logic           clamped;
    } kon_res_t;

endpackage
`default_nettype wire

FILE: design/kon_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kon_ram
// generic single-write, single-read memory with registered read data
// ----------------------------------------------------------------------------
module kon_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

FILE: design/kon_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kon_mul
// shared 32x32 unsigned multiplier used for powers and coefficient products
// ----------------------------------------------------------------------------
module kon_mul (
    input  wire logic [kon_pkg::Q_W-1:0]    op_x,
    input  wire logic [kon_pkg::Q_W-1:0]    op_y,
    output logic      [kon_pkg::PROD_W-1:0] prod
);

    assign prod = kon_pkg::PROD_W'(op_x) * kon_pkg::PROD_W'(op_y);

endmodule
`default_nettype wire

FILE: design/kon_seq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kon_seq
// sequencer and datapath: builds each term by repeated multiplication,
// scales it by its coefficient and accumulates with saturation
// ----------------------------------------------------------------------------
module kon_seq (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire kon_pkg::kon_cfg_t              cfg,
    input  wire logic                           start,
    input  wire logic [kon_pkg::Q_W-1:0]        rel,
    input  wire logic                           out_free,
    input  wire logic [kon_pkg::COEF_W-1:0]     rd_data,
    output logic      [kon_pkg::ADDR_W-1:0]     rd_addr,
    output logic                                idle,
    output kon_pkg::kon_res_t                   res
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_COEF = 3'd2;
    localparam logic [2:0] ST_ACC  = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    localparam int CW = kon_pkg::CNT_W;
    localparam int QW = kon_pkg::Q_W;

    logic [2:0]                    state_reg, state_next;
    logic [QW-1:0]                 a_reg, a_next;
    logic [QW-1:0]                 b_reg, b_next;
    logic [QW-1:0]                 p_reg, p_next;
    logic [kon_pkg::TERM_W-1:0]    term_reg, term_next;
    logic [kon_pkg::ACC_W-1:0]     acc_reg, acc_next;
    logic [CW-1:0]                 i_reg, i_next;
    logic [CW-1:0]                 m_reg, m_next;
    logic [CW-1:0]                 hi_reg, hi_next;
    logic [CW-1:0]                 ea_reg, ea_next;
    logic [CW-1:0]                 eb_reg, eb_next;

    logic [CW-1:0]                 n_eff;
    logic [CW-1:0]                 m_eff;
    logic [QW-1:0]                 r_sat;
    logic [QW-1:0]                 u_val;
    logic [QW-1:0]                 op_x;
    logic [QW-1:0]                 op_y;
    logic [kon_pkg::PROD_W-1:0]    prod;
    logic [kon_pkg::PROD_W-1:0]    rnd;
    logic [kon_pkg::ACC_W-1:0]     sum;

    kon_mul u_mul (
        .op_x (op_x),
        .op_y (op_y),
        .prod (prod)
    );

    assign rd_addr = i_reg[kon_pkg::ADDR_W-1:0];
    assign idle    = (state_reg == ST_IDLE);

    always_comb begin
        n_eff = CW'(cfg.num_components);
        if (n_eff > CW'(kon_pkg::MAX_COMPONENTS)) begin
            n_eff = CW'(kon_pkg::MAX_COMPONENTS);
        end
        m_eff = CW'(cfg.threshold_count);
        r_sat = (rel > kon_pkg::Q_ONE) ? kon_pkg::Q_ONE : rel;
        u_val = kon_pkg::Q_ONE - r_sat;
    end

    // operand select for the shared multiplier
    always_comb begin
        if (state_reg == ST_COEF) begin
            op_x = QW'(rd_data);
            op_y = p_reg;
        end else begin
            op_x = p_reg;
            op_y = (ea_reg != '0) ? a_reg : b_reg;
        end
        rnd = prod + kon_pkg::Q_HALF;
        sum = acc_reg + kon_pkg::ACC_W'(term_reg);
    end

    // result with clamp
    always_comb begin
        res.valid = (state_reg == ST_FIN);
        if (cfg.method == kon_pkg::METHOD_SUCCESS) begin
            if (acc_reg > kon_pkg::ACC_W'(kon_pkg::Q_ONE)) begin
                res.value   = kon_pkg::Q_ONE;
                res.clamped = 1'b1;
            end else begin
                res.value   = acc_reg[QW-1:0];
                res.clamped = 1'b0;
            end
        end else begin
            if (acc_reg > kon_pkg::ACC_W'(kon_pkg::Q_ONE)) begin
                res.value   = '0;
                res.clamped = 1'b1;
            end else begin
                res.value   = kon_pkg::Q_ONE - acc_reg[QW-1:0];
                res.clamped = 1'b0;
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        p_next     = p_reg;
        term_next  = term_reg;
        acc_next   = acc_reg;
        i_next     = i_reg;
        m_next     = m_reg;
        hi_next    = hi_reg;
        ea_next    = ea_reg;
        eb_next    = eb_reg;
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    if (cfg.method == kon_pkg::METHOD_SUCCESS) begin
                        a_next = r_sat;
                        b_next = u_val;
                    end else begin
                        a_next = u_val;
                        b_next = r_sat;
                    end
                    acc_next = '0;
                    i_next   = '0;
                    p_next   = kon_pkg::Q_ONE;
                    m_next   = m_eff;
                    hi_next  = n_eff - m_eff;
                    ea_next  = m_eff;
                    eb_next  = n_eff - m_eff;
                    // threshold above n leaves an empty sum
                    state_next = (m_eff > n_eff) ? ST_FIN : ST_MUL;
                end
            end
            ST_MUL: begin
                if (ea_reg != '0) begin
                    p_next  = rnd[2*QW-2:QW-1];
                    ea_next = ea_reg - 1'b1;
                end else if (eb_reg != '0) begin
                    p_next  = rnd[2*QW-2:QW-1];
                    eb_next = eb_reg - 1'b1;
                end else begin
                    state_next = ST_COEF;
                end
            end
            ST_COEF: begin
                term_next  = prod[kon_pkg::TERM_W-1:0];
                state_next = ST_ACC;
            end
            ST_ACC: begin
                acc_next = (sum > kon_pkg::ACC_CAP) ? kon_pkg::ACC_CAP : sum;
                if (i_reg == hi_reg) begin
                    state_next = ST_FIN;
                end else begin
                    i_next     = i_reg + 1'b1;
                    ea_next    = m_reg + i_reg + 1'b1;
                    eb_next    = hi_reg - i_reg - 1'b1;
                    p_next     = kon_pkg::Q_ONE;
                    state_next = ST_MUL;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
        a_reg    <= a_next;
        b_reg    <= b_next;
        p_reg    <= p_next;
        term_reg <= term_next;
        acc_reg  <= acc_next;
        i_reg    <= i_next;
        m_reg    <= m_next;
        hi_reg   <= hi_next;
        ea_reg   <= ea_next;
        eb_reg   <= eb_next;
    end

endmodule
`default_nettype wire

FILE: design/k_of_n_identical_reliability_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// k_of_n_identical_reliability_top
// k-out-of-n system reliability of identical components in q1.31
// ----------------------------------------------------------------------------
// a load request (s_tuser = 0) writes one binomial coefficient into the
// 33-entry table and returns nothing; entries must be loaded before an
// evaluation reads them. an evaluate request (s_tuser = 1) takes the
// component reliability r and returns one result: in success mode the
// sum of c[i] * r^(m+i) * u^(n-m-i), in failure mode one minus the sum of
// c[i] * u^(m+i) * r^(n-m-i), clamped to [0,1] with m_tuser flagging the
// clamp. one shared 32x32 multiplier does every product: each term is
// built by repeated multiplication, then a check that the powers are done,
// one coefficient product and one accumulate; s_tready stays low while an
// evaluation runs. the result sits in an output register, so a following
// request is taken while it waits. configuration is written through
// cfg_wr_en/cfg_addr/cfg_wdata; the user must do so only while idle, as
// the block itself does not enforce it.
// ----------------------------------------------------------------------------
module k_of_n_identical_reliability_top (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // configuration write port
    input  wire logic                                cfg_wr_en,
    input  wire logic [kon_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  wire logic [kon_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    // request stream
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // coef_index[5:0], coef_value[35:6], reliability[67:36], zero pad
    input  wire logic [kon_pkg::S_TDATA_W-1:0]       s_tdata,
    // cmd
    input  wire logic                                s_tuser,
    // result stream
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // system_reliability[31:0]
    output logic      [kon_pkg::M_TDATA_W-1:0]       m_tdata,
    // clamped
    output logic                                     m_tuser
);

    localparam int CW = kon_pkg::CNT_W;

    // configuration registers
    logic [kon_pkg::FIELD_W-1:0] num_components_reg;
    logic [kon_pkg::FIELD_W-1:0] threshold_count_reg;
    logic                        method_reg;
    kon_pkg::kon_cfg_t           cfg;

    // output register
    logic                          m_tvalid_reg, m_tvalid_next;
    logic [kon_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                          m_tuser_reg, m_tuser_next;

    logic                          s_req;
    logic                          seq_idle;
    logic                          eval_start;
    logic                          load_wr;
    logic [CW-1:0]                 load_idx;
    logic                          out_free;
    logic [kon_pkg::ADDR_W-1:0]    rd_addr;
    logic [kon_pkg::COEF_W-1:0]    rd_data;
    kon_pkg::kon_res_t             res;

    assign cfg.num_components  = num_components_reg;
    assign cfg.threshold_count = threshold_count_reg;
    assign cfg.method          = method_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_components_reg  <= kon_pkg::FIELD_W'(1);
            threshold_count_reg <= kon_pkg::FIELD_W'(1);
            method_reg          <= kon_pkg::METHOD_SUCCESS;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                kon_pkg::REG_NUM_COMPONENTS:  num_components_reg  <= cfg_wdata;
                kon_pkg::REG_THRESHOLD_COUNT: threshold_count_reg <= cfg_wdata;
                kon_pkg::REG_METHOD:          method_reg          <= cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    // request decode
    assign s_tready   = seq_idle;
    assign s_req      = s_tvalid && s_tready;
    assign eval_start = s_req && (s_tuser == kon_pkg::CMD_EVAL);
    assign load_idx   = CW'(s_tdata[5:0]);
    // loads past the last table entry are dropped
    assign load_wr    = s_req && (s_tuser == kon_pkg::CMD_LOAD)
                        && (load_idx <= CW'(kon_pkg::MAX_COMPONENTS));

    kon_ram #(
        .WIDTH (kon_pkg::COEF_W),
        .DEPTH (kon_pkg::TABLE_DEPTH)
    ) u_coef_table (
        .aclk    (aclk),
        .wr_en   (load_wr),
        .wr_addr (load_idx[kon_pkg::ADDR_W-1:0]),
        .wr_data (s_tdata[35:6]),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    kon_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .start    (eval_start),
        .rel      (s_tdata[67:36]),
        .out_free (out_free),
        .rd_data  (rd_data),
        .rd_addr  (rd_addr),
        .idle     (seq_idle),
        .res      (res)
    );

    // output register frees up in the cycle it is taken
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        if (res.valid && out_free) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = res.value;
            m_tuser_next  = res.clamped;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule
`default_nettype wire

FILE: verif/kon_test_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kon_test_pkg
// scoreboard for the k-out-of-n reliability block: own copy of the table
// and settings, expected reliability and clamp flag per evaluate request
// ----------------------------------------------------------------------------
package kon_test_pkg;
    import kon_pkg::*;

    class system_reliability_checker;
        logic [COEF_W-1:0]  coef_table [TABLE_DEPTH];
        logic [FIELD_W-1:0] num_components;
        logic [FIELD_W-1:0] threshold_count;
        logic               method;
        // {clamped, system_reliability}, oldest first
        logic [Q_W:0]       expected_reliability [$];
        int                 mismatch_count;

        function new();
            foreach (coef_table[i]) coef_table[i] = '0;
            num_components  = 6'd1;
            threshold_count = 6'd1;
            method          = METHOD_SUCCESS;
            mismatch_count  = 0;
        endfunction

        function void set_config(logic [FIELD_W-1:0] n, logic [FIELD_W-1:0] m, logic meth);
            num_components  = n;
            threshold_count = m;
            method          = meth;
        endfunction

        // q1.31 product, rounded half up
        function logic [63:0] qmul(logic [63:0] a, logic [63:0] b);
            return (a * b + Q_HALF) >> 31;
        endfunction

        function logic [Q_W:0] reliability_of(logic [Q_W-1:0] rel);
            logic [63:0] r, u, lead_base, tail_base, p, term, acc, value;
            int          n, m, hi;
            logic        clamp;
            r = 64'(rel);
            if (r > 64'(Q_ONE)) r = 64'(Q_ONE);
            u = 64'(Q_ONE) - r;
            // failure mode counts failed components first
            lead_base = (method == METHOD_FAILURE) ? u : r;
            tail_base = (method == METHOD_FAILURE) ? r : u;
            n = int'(num_components);
            if (n > MAX_COMPONENTS) n = MAX_COMPONENTS;
            m = int'(threshold_count);
            acc   = '0;
            clamp = 1'b0;
            if (m <= n) begin
                hi = n - m;
                for (int i = 0; i <= hi; i++) begin
                    p = 64'(Q_ONE);
                    for (int k = 0; k < m + i; k++) p = qmul(p, lead_base);
                    for (int k = 0; k < hi - i; k++) p = qmul(p, tail_base);
                    term = 64'(coef_table[i]) * p;
                    if (acc > 64'(ACC_CAP) - term) acc = 64'(ACC_CAP);
                    else acc = acc + term;
                end
            end
            if (acc > 64'(Q_ONE)) begin
                clamp = 1'b1;
                value = (method == METHOD_FAILURE) ? 64'd0 : 64'(Q_ONE);
            end else begin
                value = (method == METHOD_FAILURE) ? 64'(Q_ONE) - acc : acc;
            end
            return {clamp, value[Q_W-1:0]};
        endfunction

        function void note_request(logic cmd, logic [5:0] idx, logic [COEF_W-1:0] val,
                                   logic [Q_W-1:0] rel);
            if (cmd == CMD_LOAD) begin
                if (idx <= MAX_COMPONENTS) coef_table[idx] = val;
            end else begin
                expected_reliability.push_back(reliability_of(rel));
            end
        endfunction

        function void check_result(logic [Q_W-1:0] value, logic clamped);
            logic [Q_W:0] want;
            if (expected_reliability.size() == 0) begin
                $display("%0t: unexpected result system_reliability %h clamped %b",
                         $time, value, clamped);
                mismatch_count++;
                return;
            end
            want = expected_reliability.pop_front();
            if (value !== want[Q_W-1:0]) begin
                $display("%0t: system_reliability expected %h actual %h",
                         $time, want[Q_W-1:0], value);
                mismatch_count++;
            end
            if (clamped !== want[Q_W]) begin
                $display("%0t: clamped expected %b actual %b", $time, want[Q_W], clamped);
                mismatch_count++;
            end
        endfunction

        function int pending();
            return expected_reliability.size();
        endfunction
    endclass

endpackage

FILE: verif/k_of_n_identical_reliability_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// k_of_n_identical_reliability_top_test
// load and evaluate requests with random gaps on both streams, every result
// checked against the scoreboard
// ----------------------------------------------------------------------------
// a short directed part covers reset settings, zero counts, n above the
// table size, a threshold above n, reliability above one, ignored loads and
// the clamp in both modes. the random part then runs phases: each phase
// writes a new setting while idle, mostly loads the true binomial row for it
// and evaluates random samples; other phases mix in random coefficient loads
// ----------------------------------------------------------------------------
module k_of_n_identical_reliability_top_test;
    import kon_pkg::*;
    import kon_test_pkg::*;

    // about 1170 requests once the last phase runs over, directed part included
    localparam int ITEM_TARGET = 1150;
    // slowest correct run: every request an evaluate at n = 32, m = 0 plus the
    // longest gap on each side; the limit takes that four times over
    localparam int CYCLE_LIMIT = 6_000_000;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 s_tuser   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;

    system_reliability_checker sb;
    int requests_sent = 0;
    int cycle_count;
    int stall_left = 0;
    // phases with no idling on either side
    bit no_idle = 1'b0;

    k_of_n_identical_reliability_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // mostly short gaps, now and then a long one
    function automatic int idle_length();
        return ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 4);
    endfunction

    function automatic longint unsigned binom(int n, int k);
        longint unsigned c;
        c = 1;
        if (k < 0 || k > n) return 0;
        for (int j = 1; j <= k; j++) c = c * longint'(n - k + j) / longint'(j);
        return c;
    endfunction

    function automatic logic [Q_W-1:0] pick_reliability();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return Q_ONE;
            2:       return $urandom;                       // may exceed one
            3:       return Q_ONE - $urandom_range(0, 1000);  // close to one
            default: return $urandom_range(0, 32'h8000_0000);
        endcase
    endfunction

    function automatic logic [COEF_W-1:0] noise_coef();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return COEF_W'($urandom);
            default: return COEF_W'($urandom_range(0, 601080390));
        endcase
    endfunction

    // one request; the scoreboard learns of it once the handshake is done
    task automatic send_request(input logic cmd, input logic [5:0] idx,
                                input logic [COEF_W-1:0] val, input logic [Q_W-1:0] rel);
        int gap;
        gap = (no_idle || $urandom_range(0, 1) == 0) ? 0 : idle_length();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {4'b0, rel, val, idx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_request(cmd, idx, val, rel);
        // loads beyond the table are ignored by the block and not counted
        if (!(cmd == CMD_LOAD && idx > MAX_COMPONENTS)) requests_sent++;
    endtask

    // unused fields carry random filler
    task automatic send_load(input logic [5:0] idx, input logic [COEF_W-1:0] val);
        send_request(CMD_LOAD, idx, val, $urandom);
    endtask

    task automatic send_eval(input logic [Q_W-1:0] rel);
        send_request(CMD_EVAL, 6'($urandom), COEF_W'($urandom), rel);
    endtask

    // stop sending, let every result come back, then give the block a margin
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // all three registers, method with random bits above its one bit
    task automatic configure(input logic [5:0] n, input logic [5:0] m, input logic meth);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= REG_NUM_COMPONENTS;
        cfg_wdata <= n;
        @(posedge aclk);
        cfg_addr  <= REG_THRESHOLD_COUNT;
        cfg_wdata <= m;
        @(posedge aclk);
        cfg_addr  <= REG_METHOD;
        cfg_wdata <= {5'($urandom), meth};
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.set_config(n, m, meth);
    endtask

    // one setting: true binomial row or random coefficients, then samples
    task automatic run_phase(input logic [5:0] n, input logic [5:0] m, input logic meth);
        int n_eff, evals;
        bit shaped;
        n_eff   = (n > MAX_COMPONENTS) ? MAX_COMPONENTS : int'(n);
        shaped  = $urandom_range(0, 3) != 0;
        wait_idle();
        no_idle = $urandom_range(0, 4) == 0;
        configure(n, m, meth);
        if (shaped && int'(m) <= n_eff) begin
            for (int i = 0; i <= n_eff - int'(m); i++)
                send_load(6'(i), COEF_W'(binom(n_eff, int'(m) + i)));
        end
        // large n makes each sample slow, so few of them
        evals = (n_eff > 8) ? $urandom_range(2, 6) : $urandom_range(15, 50);
        repeat (evals) begin
            if (!shaped && $urandom_range(0, 2) == 0)
                send_load(6'($urandom_range(0, 63)), noise_coef());
            send_eval(pick_reliability());
        end
    endtask

    // result side: check on handshake, then pick the next ready value
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
            if (stall_left > 0) begin
                stall_left = stall_left - 1;
                m_tready   <= 1'b0;
            end else if (!no_idle && $urandom_range(0, 2) == 0) begin
                stall_left = idle_length() - 1;
                m_tready   <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // watchdog
    initial begin
        for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge aclk);
        $display("k_of_n_identical_reliability_top_test: FAIL");
        $finish;
    end

    initial begin : main_flow
        logic [5:0] n_pick, m_pick;
        int         n_eff;
        sb = new();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset setting n = 1, m = 1, success: result equals r times c0
        send_load(6'd0, 30'd1);
        send_eval(32'h0000_0000);
        send_eval(Q_ONE);
        send_eval(32'hFFFF_FFFF);       // above one, taken as one
        send_eval(32'h4000_0000);
        send_load(6'd32, 30'd601080390); // top entry, largest coefficient
        send_load(6'd63, 30'h3FFF_FFFF); // beyond the table, ignored

        // zero counts: single term c0 * 1.0
        wait_idle();
        configure(6'd0, 6'd0, METHOD_SUCCESS);
        send_eval(32'h1234_5678);
        send_load(6'd0, 30'd2);
        send_eval(32'h0000_0001);       // sum is two, clamps to one
        wait_idle();
        configure(6'd0, 6'd0, METHOD_FAILURE);
        send_eval($urandom);            // clamps to zero
        send_load(6'd0, 30'h3FFF_FFFF);
        send_eval(Q_ONE);

        // n above the table size, taken as 32
        wait_idle();
        configure(6'd63, 6'd32, METHOD_FAILURE);
        send_load(6'd0, 30'd1);
        send_eval(32'h7FFF_FFFF);
        send_eval(32'h0000_0000);

        // threshold above n: empty sum in both modes
        wait_idle();
        configure(6'd2, 6'd63, METHOD_SUCCESS);
        send_eval(pick_reliability());
        wait_idle();
        configure(6'd2, 6'd63, METHOD_FAILURE);
        send_eval(pick_reliability());

        // fill every entry so that no later read finds one unwritten
        for (int i = 0; i <= MAX_COMPONENTS; i++) send_load(6'(i), noise_coef());

        // full size first, then random settings
        run_phase(6'd32, 6'd1, METHOD_SUCCESS);
        while (requests_sent < ITEM_TARGET) begin
            if ($urandom_range(0, 6) == 0) n_pick = 6'($urandom_range(9, 63));
            else n_pick = 6'($urandom_range(0, 8));
            n_eff = (n_pick > MAX_COMPONENTS) ? MAX_COMPONENTS : int'(n_pick);
            case ($urandom_range(0, 9))
                0:       m_pick = 6'd0;
                1:       m_pick = 6'($urandom_range(n_eff + 1, 63));
                default: m_pick = 6'($urandom_range(1, (n_eff > 0) ? n_eff : 1));
            endcase
            run_phase(n_pick, m_pick, 1'($urandom_range(0, 1)));
        end

        // drain and watch for stray results
        wait_idle();
        repeat (64) @(posedge aclk);
        if (sb.mismatch_count == 0)
            $display("k_of_n_identical_reliability_top_test: PASS");
        else
            $display("k_of_n_identical_reliability_top_test: FAIL");
        $finish;
    end

endmodule

FILE: k_of_n_identical_reliability_top.f
design/kon_pkg.sv
design/kon_ram.sv
design/kon_mul.sv
design/kon_seq.sv
design/k_of_n_identical_reliability_top.sv
verif/kon_test_pkg.sv
verif/k_of_n_identical_reliability_top_test.sv
